// File: sv/nmea7s_pkg.sv
// Shared types, constants and segment tables for the NMEA time display core.
// No dependencies; every other file refers to this package by scoped names.
package nmea7s_pkg;

  // Result queue between parser and arithmetic back end.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Sentence framing.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam int unsigned TIME_DIGITS = 6;
  localparam int unsigned DATE_DIGITS = 4;
  localparam int unsigned SKIP_COMMAS = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_DISPLAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HOURS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MINUTES      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_START         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_END           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_24H        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEADING_ZERO = 3'd6;

  typedef struct packed {
    logic              mirror_display;
    logic signed [5:0] zone_hours;
    logic [5:0]        zone_minutes;
    logic [10:0]       dst_start;
    logic [10:0]       dst_end;
    logic              format_24h;
    logic              trim_leading_zero;
  } cfg_t;

  // One complete sentence: six time digits and four date digits, BCD,
  // first received in the top nibble.
  typedef struct packed {
    logic [23:0] time_digits;
    logic [15:0] date_digits;
  } stamp_t;

  localparam logic [6:0] SEG_MIRRORED [10] = '{
    7'h3F, 7'h30, 7'h5B, 7'h79, 7'h74, 7'h6D, 7'h6F, 7'h38, 7'h7F, 7'h7D
  };
  localparam logic [6:0] SEG_PLAIN [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  localparam logic [3:0] COLON_MIRRORED [4] = '{4'd0, 4'd4, 4'd12, 4'd8};
  localparam logic [3:0] COLON_PLAIN    [4] = '{4'd0, 4'd8, 4'd12, 4'd4};

  function automatic logic [6:0] seg_code(input logic [3:0] digit, input logic mirror);
    logic [3:0] idx;
    idx = (digit > 4'd9) ? digit - 4'd10 : digit;
    return mirror ? SEG_MIRRORED[idx] : SEG_PLAIN[idx];
  endfunction

endpackage

// File: sv/nmea7s_ifs.sv
// Handshake channels of the NMEA time display core: byte in, result out, config.
// Depends on nmea7s_pkg for the config port widths.
interface nmea7s_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmea7s_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] hour_shown;
  logic [5:0] minute_shown;
  logic [6:0] second_shown;
  logic [6:0] hour_tens_segments;
  logic [6:0] hour_ones_segments;
  logic [6:0] minute_tens_segments;
  logic [6:0] minute_ones_segments;
  logic [4:0] punct_segments;
  modport source (output valid, output hour_shown, output minute_shown,
                  output second_shown, output hour_tens_segments,
                  output hour_ones_segments, output minute_tens_segments,
                  output minute_ones_segments, output punct_segments, input ready);
  modport sink   (input valid, input hour_shown, input minute_shown,
                  input second_shown, input hour_tens_segments,
                  input hour_ones_segments, input minute_tens_segments,
                  input minute_ones_segments, input punct_segments, output ready);
endinterface

interface nmea7s_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [nmea7s_pkg::CFG_IDX_W-1:0]  index;
  logic [nmea7s_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/nmea7s_parse.sv
// Front end: sentence parser that collects time and date digits per byte.
// Depends on nmea7s_pkg and nmea7s_byte_if.
module nmea7s_parse (
  input  logic               clk,
  input  logic               rst,
  nmea7s_byte_if.sink        rx,
  input  logic               q_full,
  output logic               push,
  output nmea7s_pkg::stamp_t push_data
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_FIRST_COMMA, PH_TIME, PH_COMMAS, PH_DATE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  comma_count, comma_count_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [23:0] time_digits, time_digits_next;
  logic [15:0] date_digits, date_digits_next;
  logic        accept, is_digit, is_comma;
  logic [3:0]  digit;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign is_digit = (rx.rx_byte >= nmea7s_pkg::CHAR_ZERO) &&
                    (rx.rx_byte <= nmea7s_pkg::CHAR_NINE);
  assign is_comma = (rx.rx_byte == nmea7s_pkg::CHAR_COMMA);
  assign digit    = rx.rx_byte[3:0];

  always_comb begin
    phase_next       = phase;
    comma_count_next = comma_count;
    digit_count_next = digit_count;
    time_digits_next = time_digits;
    date_digits_next = date_digits;
    push             = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_FIRST_COMMA: begin
          if (is_comma) begin
            phase_next       = PH_TIME;
            digit_count_next = '0;
            time_digits_next = '0;
          end
        end
        PH_TIME: begin
          if (!is_digit) begin
            phase_next = PH_WAIT;
          end else begin
            time_digits_next = {time_digits[19:0], digit};
            digit_count_next = digit_count + 3'd1;
            if (digit_count_next >= 3'(nmea7s_pkg::TIME_DIGITS)) begin
              phase_next       = PH_COMMAS;
              comma_count_next = '0;
            end
          end
        end
        PH_COMMAS: begin
          if (is_comma) begin
            comma_count_next = comma_count + 4'd1;
            if (comma_count_next >= 4'(nmea7s_pkg::SKIP_COMMAS)) begin
              phase_next       = PH_DATE;
              digit_count_next = '0;
              date_digits_next = '0;
            end
          end
        end
        PH_DATE: begin
          if (!is_digit) begin
            phase_next = PH_WAIT;
          end else begin
            date_digits_next = {date_digits[11:0], digit};
            digit_count_next = digit_count + 3'd1;
            if (digit_count_next >= 3'(nmea7s_pkg::DATE_DIGITS)) begin
              phase_next = PH_WAIT;
              push       = 1'b1;
            end
          end
        end
        default: begin
          // idle, and any stray code: look for the sentence start
          phase_next = (rx.rx_byte == nmea7s_pkg::CHAR_DOLLAR) ? PH_FIRST_COMMA : PH_WAIT;
        end
      endcase
    end
  end

  assign push_data.time_digits = time_digits;
  assign push_data.date_digits = date_digits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      comma_count <= '0;
      digit_count <= '0;
      time_digits <= '0;
      date_digits <= '0;
    end else begin
      phase       <= phase_next;
      comma_count <= comma_count_next;
      digit_count <= digit_count_next;
      time_digits <= time_digits_next;
      date_digits <= date_digits_next;
    end
  end

endmodule

// File: sv/nmea7s_fifo.sv
// Short queue of parsed sentences between the parser and the back end.
// Depends on nmea7s_pkg for depth and entry type.
module nmea7s_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nmea7s_pkg::stamp_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output nmea7s_pkg::stamp_t head
);

  nmea7s_pkg::stamp_t                entries [nmea7s_pkg::QDEPTH];
  logic [nmea7s_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [nmea7s_pkg::QCNT_W-1:0]     count;
  logic                              do_push, do_pop;

  assign full       = (count == nmea7s_pkg::QCNT_W'(nmea7s_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [nmea7s_pkg::QPTR_W-1:0] bump(
    input logic [nmea7s_pkg::QPTR_W-1:0] p);
    return (p == nmea7s_pkg::QPTR_W'(nmea7s_pkg::QDEPTH - 1)) ? '0 :
           p + nmea7s_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + nmea7s_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - nmea7s_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("sentence pushed into a full queue");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= nmea7s_pkg::QCNT_W'(nmea7s_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

// File: sv/nmea7s_calc.sv
// Back end: two-stage zone/DST arithmetic and segment encoding with output register.
// Depends on nmea7s_pkg and nmea7s_res_if.
module nmea7s_calc (
  input  logic               clk,
  input  logic               rst,
  input  nmea7s_pkg::cfg_t   cfg,
  input  logic               head_valid,
  input  nmea7s_pkg::stamp_t head,
  output logic               pop,
  nmea7s_res_if.source       res
);

  // stage 1 signals
  logic [6:0]        hour_raw, minute_raw, second_raw, day, month;
  logic [13:0]       md;
  logic signed [5:0] zh, zh_mod;
  logic [5:0]        zm_mod, minute_mod;
  logic [7:0]        msum;
  logic              carry, dst;
  logic signed [8:0] hsum;
  logic [4:0]        hour24;

  logic              s1_valid;
  logic [4:0]        s1_hour;
  logic [5:0]        s1_minute;
  logic [6:0]        s1_second;

  // stage 2 signals
  logic              s1_adv, s2_adv;
  logic [1:0]        colon_idx;
  logic [3:0]        colon;
  logic              pm;
  logic [4:0]        hdisp;
  logic [1:0]        h_tens;
  logic [3:0]        h_ones, m_tens, m_ones;

  function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
    return ({3'b0, hi} << 3) + ({3'b0, hi} << 1) + {3'b0, lo};
  endfunction

  // biased hour sum reaches 148 (hour 99, zone +23, carry, DST), so take 8 bits
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd96) r = r - 8'd96;
    if (r >= 8'd48) r = r - 8'd48;
    if (r >= 8'd24) r = r - 8'd24;
    return r[4:0];
  endfunction

  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    t = 4'd0;
    if (v >= 6'd10) t = 4'd1;
    if (v >= 6'd20) t = 4'd2;
    if (v >= 6'd30) t = 4'd3;
    if (v >= 6'd40) t = 4'd4;
    if (v >= 6'd50) t = 4'd5;
    return t;
  endfunction

  assign s2_adv = !res.valid || res.ready;
  assign s1_adv = !s1_valid || s2_adv;
  assign pop    = head_valid && s1_adv;

  // Stage 1: digits to numbers, zone offset, carry, DST, wrap to 0..23.
  always_comb begin
    hour_raw   = two_digits(head.time_digits[23:20], head.time_digits[19:16]);
    minute_raw = two_digits(head.time_digits[15:12], head.time_digits[11:8]);
    second_raw = two_digits(head.time_digits[7:4], head.time_digits[3:0]);
    day        = two_digits(head.date_digits[15:12], head.date_digits[11:8]);
    month      = two_digits(head.date_digits[7:4], head.date_digits[3:0]);
    md         = (14'(month) << 6) + (14'(month) << 5) + (14'(month) << 2) + 14'(day);
    zh         = $signed(cfg.zone_hours);
    if (zh >= 6'sd24) begin
      zh_mod = zh - 6'sd24;
    end else if (zh <= -6'sd24) begin
      zh_mod = zh + 6'sd24;
    end else begin
      zh_mod = zh;
    end
    zm_mod = (cfg.zone_minutes >= 6'd60) ? cfg.zone_minutes - 6'd60 : cfg.zone_minutes;
    msum   = {1'b0, minute_raw} + {2'b0, zm_mod};
    carry  = (msum >= 8'd60);
    if (msum >= 8'd120) begin
      minute_mod = 6'(msum - 8'd120);
    end else if (msum >= 8'd60) begin
      minute_mod = 6'(msum - 8'd60);
    end else begin
      minute_mod = 6'(msum);
    end
    dst = (cfg.dst_start != '0) && (md >= {3'b0, cfg.dst_start}) &&
          (md < {3'b0, cfg.dst_end});
    // bias by 24 so the sum is never negative before the wrap
    hsum = $signed({2'b0, hour_raw}) + $signed({{3{zh_mod[5]}}, zh_mod}) +
           $signed({8'b0, carry}) + $signed({8'b0, dst}) + 9'sd24;
    hour24 = mod24(hsum[7:0]);
  end

  // Stage 2: optional 12-hour format, punctuation, digit split and segment lookup.
  always_comb begin
    if (s1_second >= 7'd45) begin
      colon_idx = 2'd3;
    end else if (s1_second >= 7'd30) begin
      colon_idx = 2'd2;
    end else if (s1_second >= 7'd15) begin
      colon_idx = 2'd1;
    end else begin
      colon_idx = 2'd0;
    end
    colon = cfg.mirror_display ? nmea7s_pkg::COLON_MIRRORED[colon_idx] :
                                 nmea7s_pkg::COLON_PLAIN[colon_idx];
    pm    = 1'b0;
    hdisp = s1_hour;
    if (!cfg.format_24h) begin
      pm    = (s1_hour >= 5'd12);
      hdisp = pm ? s1_hour - 5'd12 : s1_hour;
      if (hdisp == 5'd0) hdisp = 5'd12;
    end
    if (hdisp >= 5'd20) begin
      h_tens = 2'd2;
    end else if (hdisp >= 5'd10) begin
      h_tens = 2'd1;
    end else begin
      h_tens = 2'd0;
    end
    h_ones = 4'(hdisp - ({3'b0, h_tens} << 3) - ({3'b0, h_tens} << 1));
    m_tens = tens_of(s1_minute);
    m_ones = 4'(s1_minute - ({2'b0, m_tens} << 3) - ({2'b0, m_tens} << 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= head_valid;
      end
      if (s2_adv) begin
        res.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_hour   <= hour24;
      s1_minute <= minute_mod;
      s1_second <= second_raw;
    end
    if (s2_adv && s1_valid) begin
      res.hour_shown           <= hdisp;
      res.minute_shown         <= s1_minute;
      res.second_shown         <= s1_second;
      res.hour_tens_segments   <= (cfg.trim_leading_zero && hdisp < 5'd10) ? 7'd0 :
                                  nmea7s_pkg::seg_code({2'b0, h_tens}, cfg.mirror_display);
      res.hour_ones_segments   <= nmea7s_pkg::seg_code(h_ones, cfg.mirror_display);
      res.minute_tens_segments <= nmea7s_pkg::seg_code(m_tens, cfg.mirror_display);
      res.minute_ones_segments <= nmea7s_pkg::seg_code(m_ones, cfg.mirror_display);
      res.punct_segments       <= {pm, colon | {2'b0, ~s1_second[0], 1'b0}};
    end
  end

  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.hour_shown < 5'd24) else $error("shown hour out of range");
  a_minute_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.minute_shown < 6'd60) else $error("shown minute out of range");
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_adv) |=> s1_valid) else $error("stage 1 word lost under stall");

endmodule

// File: sv/nmea_time_to_seven_segment_core.sv
// NMEA time to seven-segment core: parser front end, 2-word queue, 2-stage back end.
// Accepts one byte per cycle unless the queue is full; words pass queue, s1, output reg.
// Throughput is set by the parser; the queue absorbs output stalls until it is full.
// Synchronous active-high reset clears parser, queue and pipeline; config gets defaults.
// Depends on nmea7s_pkg, nmea7s_ifs, nmea7s_parse, nmea7s_fifo and nmea7s_calc.
module nmea_time_to_seven_segment_core (
  input  logic          clk,
  input  logic          rst,
  nmea7s_byte_if.sink   rx,
  nmea7s_res_if.source  res,
  nmea7s_cfg_if.sink    cfg
);

  nmea7s_pkg::cfg_t   cfg_reg;
  nmea7s_pkg::stamp_t push_data, head;
  logic               push, q_full, pop, head_valid;

  // Config writes are always taken; an index beyond the register list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.mirror_display    <= 1'b1;
      cfg_reg.zone_hours        <= -6'sd8;
      cfg_reg.zone_minutes      <= 6'd0;
      cfg_reg.dst_start         <= 11'd312;
      cfg_reg.dst_end           <= 11'd1105;
      cfg_reg.format_24h        <= 1'b1;
      cfg_reg.trim_leading_zero <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        nmea7s_pkg::CFG_MIRROR_DISPLAY:    cfg_reg.mirror_display    <= cfg.data[0];
        nmea7s_pkg::CFG_ZONE_HOURS:        cfg_reg.zone_hours        <= $signed(cfg.data[5:0]);
        nmea7s_pkg::CFG_ZONE_MINUTES:      cfg_reg.zone_minutes      <= cfg.data[5:0];
        nmea7s_pkg::CFG_DST_START:         cfg_reg.dst_start         <= cfg.data[10:0];
        nmea7s_pkg::CFG_DST_END:           cfg_reg.dst_end           <= cfg.data[10:0];
        nmea7s_pkg::CFG_FORMAT_24H:        cfg_reg.format_24h        <= cfg.data[0];
        nmea7s_pkg::CFG_TRIM_LEADING_ZERO: cfg_reg.trim_leading_zero <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Front end: classify bytes, collect digits, push one word per full sentence.
  nmea7s_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple parser from the arithmetic so either side can stall on its own.
  nmea7s_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: zone, DST and format math, then segment codes into the output register.
  nmea7s_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_reg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );

endmodule
